>>> design/srfm_pkg.sv
// Shared types and constants for the stream first-match replace block.
// No dependencies; imported by every module of the block.
package srfm_pkg;

  // Window geometry
  localparam int MAX_PATTERN     = 8;
  localparam int MAX_REPLACEMENT = 8;
  localparam int BYTE_W          = 8;
  localparam int WIN_IDX_W       = $clog2(MAX_PATTERN);
  localparam int CNT_W           = $clog2(MAX_PATTERN + 1);

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int LEN_W      = 4;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_BYTES  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LENGTH = 2'd3;

  typedef logic [BYTE_W-1:0] byte_t;

  // Per-cell control
  typedef struct packed {
    logic is_new;   // this cell takes the incoming byte
    logic shift;    // window moves one place toward the oldest end
  } cell_ctrl_t;

  // Window control from the sequencer
  typedef struct packed {
    logic                 append;
    logic [WIN_IDX_W-1:0] slot;
    logic                 shift;
  } win_ctrl_t;

endpackage

>>> design/srfm_cell.sv
// One window cell: holds a byte, compares it against its pattern byte.
// Depends on srfm_pkg.
module srfm_cell
  import srfm_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  byte_t      new_byte,
  input  byte_t      right_in,
  input  byte_t      pat_byte,
  output byte_t      cur,
  output logic       hit
);

  byte_t held_r;
  byte_t held_nxt;

  // Current view of this slot, including a byte appended this cycle
  assign cur      = ctrl.is_new ? new_byte : held_r;
  assign hit      = (cur == pat_byte);
  assign held_nxt = ctrl.shift ? right_in : cur;

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
  end

endmodule

>>> design/srfm_window.sv
// Chain of window cells with pattern match reduction.
// Depends on srfm_pkg and srfm_cell.
module srfm_window
  import srfm_pkg::*;
(
  input  logic                      clk,
  input  win_ctrl_t                 ctrl,
  input  byte_t                     new_byte,
  input  logic [CFG_DATA_W-1:0]     pattern_bytes,
  input  logic [LEN_W-1:0]          plen,
  output byte_t                     oldest,
  output logic                      hit
);

  byte_t                  cur   [MAX_PATTERN];
  byte_t                  rin   [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] hits;
  logic [MAX_PATTERN-1:0] in_use;

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    cell_ctrl_t cctl;

    assign cctl.is_new = ctrl.append && (ctrl.slot == WIN_IDX_W'(i));
    assign cctl.shift  = ctrl.shift;

    // Last cell has no right neighbor
    if (i == MAX_PATTERN - 1) begin : g_tail
      assign rin[i] = '0;
    end else begin : g_link
      assign rin[i] = cur[i+1];
    end

    assign in_use[i] = (LEN_W'(i) < plen);

    srfm_cell u_cell (
      .clk      (clk),
      .ctrl     (cctl),
      .new_byte (new_byte),
      .right_in (rin[i]),
      .pat_byte (pattern_bytes[i*BYTE_W +: BYTE_W]),
      .cur      (cur[i]),
      .hit      (hits[i])
    );
  end

  assign oldest = cur[0];
  // Only slots below the pattern length take part
  assign hit    = &(hits | ~in_use);

endmodule

>>> design/stream_replace_first_match_core.sv
// Top level of the stream first-match replace block: config, sequencer, output reg.
// Depends on srfm_pkg and srfm_window.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------------------------
//  in      | input     | in_valid/in_stall   | in_data_byte, in_is_final
//  out     | output    | out_valid/out_stall | out_byte, out_byte_present, out_end_of_string
//  cfg     | input     | cfg_we              | cfg_index, cfg_wdata
//
// One request per cycle while each request yields at most one result and the output
// is not stalled. A match yields replacement_length results, one per cycle from the
// output register while it is not stalled; a final byte without a match flushes
// every byte left in the window, its own included.
// rst_n is synchronous: window count, mode and output valid clear, config goes to defaults.
// A stalled output register stalls the input in the same cycle.
module stream_replace_first_match_core
  import srfm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  byte_t                 in_data_byte,
  input  logic                  in_is_final,
  output logic                  out_valid,
  input  logic                  out_stall,
  output byte_t                 out_byte,
  output logic                  out_byte_present,
  output logic                  out_end_of_string,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_REPL  = 2'd1;
  localparam logic [1:0] MODE_FLUSH = 2'd2;

  // Configuration registers
  logic [CFG_DATA_W-1:0] pat_bytes_r;
  logic [LEN_W-1:0]      pat_len_r;
  logic [CFG_DATA_W-1:0] rep_bytes_r;
  logic [LEN_W-1:0]      rep_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_bytes_r <= '0;
      pat_len_r   <= LEN_W'(1);
      rep_bytes_r <= '0;
      rep_len_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PATTERN_BYTES:      pat_bytes_r <= cfg_wdata;
        REG_PATTERN_LENGTH:     pat_len_r   <= cfg_wdata[LEN_W-1:0];
        REG_REPLACEMENT_BYTES:  rep_bytes_r <= cfg_wdata;
        REG_REPLACEMENT_LENGTH: rep_len_r   <= cfg_wdata[LEN_W-1:0];
      endcase
    end
  end

  // Effective lengths
  logic [LEN_W-1:0] plen;
  logic [LEN_W-1:0] rlen;

  always_comb begin
    if (pat_len_r == '0)                        plen = LEN_W'(1);
    else if (pat_len_r > LEN_W'(MAX_PATTERN))   plen = LEN_W'(MAX_PATTERN);
    else                                        plen = pat_len_r;
    rlen = (rep_len_r > LEN_W'(MAX_REPLACEMENT)) ? LEN_W'(MAX_REPLACEMENT) : rep_len_r;
  end

  // Sequencer state
  logic [1:0]           mode_r, mode_nxt;
  logic [CNT_W-1:0]     hc_r, hc_nxt;
  logic                 replaced_r, replaced_nxt;
  logic [WIN_IDX_W-1:0] idx_r, idx_nxt;
  logic                 final_r, final_nxt;

  // Output register
  logic  out_valid_r;
  byte_t out_byte_r;
  logic  out_present_r;
  logic  out_eos_r;

  logic      advance;
  logic      acc;
  win_ctrl_t wctl;
  byte_t     win_oldest;
  logic      win_hit;

  logic [CNT_W-1:0] hc_c;
  logic [CNT_W-1:0] hc_a;
  logic             match;
  logic             emit_old;
  logic             produce;
  byte_t            res_byte;
  logic             res_present;
  logic             res_eos;

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = (mode_r != MODE_IDLE) || !advance;
  assign acc      = in_valid && !in_stall;

  srfm_window u_window (
    .clk           (clk),
    .ctrl          (wctl),
    .new_byte      (in_data_byte),
    .pattern_bytes (pat_bytes_r),
    .plen          (plen),
    .oldest        (win_oldest),
    .hit           (win_hit)
  );

  // Window fill after the incoming byte is appended
  assign hc_c     = (hc_r > CNT_W'(MAX_PATTERN - 1)) ? CNT_W'(MAX_PATTERN - 1) : hc_r;
  assign hc_a     = hc_c + CNT_W'(1);
  assign match    = (hc_a == CNT_W'(plen)) && win_hit;
  assign emit_old = (hc_a > CNT_W'(plen)) || ((hc_a == CNT_W'(plen)) && !win_hit);

  // Next state and result of this cycle
  always_comb begin
    mode_nxt     = mode_r;
    hc_nxt       = hc_r;
    replaced_nxt = replaced_r;
    idx_nxt      = idx_r;
    final_nxt    = final_r;
    produce      = 1'b0;
    res_byte     = '0;
    res_present  = 1'b1;
    res_eos      = 1'b0;
    wctl.append  = 1'b0;
    wctl.slot    = hc_c[WIN_IDX_W-1:0];
    wctl.shift   = 1'b0;

    unique case (mode_r)
      MODE_IDLE: begin
        if (acc) begin
          if (replaced_r) begin
            // pass-through after the first match
            produce  = 1'b1;
            res_byte = in_data_byte;
            res_eos  = in_is_final;
            if (in_is_final) replaced_nxt = 1'b0;
          end else begin
            wctl.append = 1'b1;
            if (match) begin
              hc_nxt       = '0;
              replaced_nxt = !in_is_final;
              if (rlen == '0) begin
                // deleted match: bare end marker if this ends the string
                if (in_is_final) begin
                  produce     = 1'b1;
                  res_present = 1'b0;
                  res_eos     = 1'b1;
                end
              end else begin
                produce  = 1'b1;
                res_byte = rep_bytes_r[BYTE_W-1:0];
                if (rlen == LEN_W'(1)) begin
                  res_eos = in_is_final;
                end else begin
                  mode_nxt  = MODE_REPL;
                  idx_nxt   = WIN_IDX_W'(1);
                  final_nxt = in_is_final;
                end
              end
            end else if (emit_old || in_is_final) begin
              wctl.shift = 1'b1;
              produce    = 1'b1;
              res_byte   = win_oldest;
              hc_nxt     = hc_a - CNT_W'(1);
              if (in_is_final) begin
                if (hc_a == CNT_W'(1)) res_eos  = 1'b1;
                else                   mode_nxt = MODE_FLUSH;
              end
            end else begin
              hc_nxt = hc_a;
            end
          end
        end
      end
      MODE_REPL: begin
        if (advance) begin
          produce  = 1'b1;
          res_byte = rep_bytes_r[{idx_r, 3'b000} +: BYTE_W];
          if ({1'b0, idx_r} == rlen - LEN_W'(1)) begin
            res_eos  = final_r;
            mode_nxt = MODE_IDLE;
          end else begin
            idx_nxt = idx_r + WIN_IDX_W'(1);
          end
        end
      end
      MODE_FLUSH: begin
        if (advance) begin
          wctl.shift = 1'b1;
          produce    = 1'b1;
          res_byte   = win_oldest;
          hc_nxt     = hc_r - CNT_W'(1);
          if (hc_r == CNT_W'(1)) begin
            res_eos  = 1'b1;
            mode_nxt = MODE_IDLE;
          end
        end
      end
      default: mode_nxt = MODE_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      hc_r        <= '0;
      replaced_r  <= 1'b0;
      idx_r       <= '0;
      final_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r     <= mode_nxt;
      hc_r       <= hc_nxt;
      replaced_r <= replaced_nxt;
      idx_r      <= idx_nxt;
      final_r    <= final_nxt;
      if (advance) out_valid_r <= produce;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte_r    <= res_byte;
      out_present_r <= res_present;
      out_eos_r     <= res_eos;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_byte          = out_byte_r;
  assign out_byte_present  = out_present_r;
  assign out_end_of_string = out_eos_r;

endmodule

>>> design/srfm_checker.sv
// Port-level checks for the stream first-match replace block, bound to its top.
// Depends on srfm_pkg and stream_replace_first_match_core.
module srfm_checker
  import srfm_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input byte_t                 in_data_byte,
  input logic                  in_is_final,
  input logic                  out_valid,
  input logic                  out_stall,
  input byte_t                 out_byte,
  input logic                  out_byte_present,
  input logic                  out_end_of_string
);

  // Reset empties the output register
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // A stalled request holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data_byte) && $stable(in_is_final))
    else $error("stalled request changed");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte)
      && $stable(out_byte_present) && $stable(out_end_of_string))
    else $error("stalled result changed");

  // A full, stalled output register holds the input off
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while output is blocked");

  // A byteless result is only the end marker, with a zero byte
  a_bare_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_present |-> out_end_of_string && (out_byte == '0))
    else $error("bare marker not at end of string");

endmodule

bind stream_replace_first_match_core srfm_checker u_srfm_checker (.*);

>>> test/testbench.sv
// Self-checking testbench for stream_replace_first_match_core.
// It predicts first-match replacement per request and checks every result in order.
// Depends on srfm_pkg and the core RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import srfm_pkg::*;

  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_ITEMS = 220;
  localparam int PLAN_ROWS    = 28;

  // One expected result of the rewritten string
  typedef struct packed {
    byte_t data;
    logic  present;
    logic  last;
  } rewritten_t;

  typedef enum logic {ROW_SETUP, ROW_BYTE} row_kind_e;
  typedef enum int {RX_FREE, RX_CHOPPY, RX_HEAVY} rx_mode_e;

  // Directed row: a full register setup or one request
  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_DATA_W-1:0] pb;
    logic [LEN_W-1:0]      pl;
    logic [CFG_DATA_W-1:0] rb;
    logic [LEN_W-1:0]      rl;
    byte_t                 data;
    logic                  fin;
    logic                  typed;
    rewritten_t            want;
  } directed_row_t;

  localparam rewritten_t NO_RESULT = '{8'h00, 1'b0, 1'b0};
  localparam rewritten_t BARE_END  = '{8'h00, 1'b0, 1'b1};
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  byte_t                 in_data_byte = '0;
  logic                  in_is_final = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  byte_t                 out_byte;
  logic                  out_byte_present;
  logic                  out_end_of_string;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_PATTERN_BYTES;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Predictor copy of the registers and the search state
  logic [CFG_DATA_W-1:0] pat_bytes = '0;
  logic [LEN_W-1:0]      pat_len = 4'd1;
  logic [CFG_DATA_W-1:0] rep_bytes = '0;
  logic [LEN_W-1:0]      rep_len = 4'd0;
  byte_t                 held [MAX_PATTERN];
  int unsigned           held_n = 0;
  bit                    replaced = 1'b0;

  rewritten_t  rewritten_q [$];
  rewritten_t  step_out [$];
  rewritten_t  got_want;
  int unsigned errors = 0;
  int unsigned burst_left = 0;
  rx_mode_e    rx_mode = RX_FREE;
  int unsigned rx_left = 0;

  // Directed plan: defaults after reset, length saturation, zero pattern length,
  // match deleted at the final byte, and the pattern shortened mid-string
  directed_row_t plan [PLAN_ROWS] = '{
    '{ROW_BYTE, 64'h0, 4'd0, 64'h0, 4'd0, 8'h00, 1'b1, 1'b1, BARE_END},
    '{ROW_BYTE, 64'h0, 4'd0, 64'h0, 4'd0, 8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1}},
    '{ROW_SETUP, 64'h636261, 4'd3, ALL_ONES, 4'd15, 8'h00, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE, 64'h0, 4'd0, 64'h0, 4'd0, 8'h78, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE, 64'h0, 4'd0, 64'h0, 4'd0, 8'h61, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE, 64'h0, 4'd0, 64'h0, 4'd0, 8'h62, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE, 64'h0, 4'd0, 64'h0, 4'd0, 8'h63, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE, 64'h0, 4'd0, 64'h0, 4'd0, 8'h79, 1'b1, 1'b0, NO_RESULT},
    '{ROW_SETUP, 64'h41, 4'd0, 64'h0201, 4'd2, 8'h00, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE, 64'h0, 4'd0, 64'h0, 4'd0, 8'h41, 1'b1, 1'b0, NO_RESULT},
    '{ROW_SETUP, ALL_ONES, 4'd15, 64'h0, 4'd0, 8'h00, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE, 64'h0, 4'd0, 64'h0, 4'd0, 8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE, 64'h0, 4'd0, 64'h0, 4'd0, 8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE, 64'h0, 4'd0, 64'h0, 4'd0, 8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE, 64'h0, 4'd0, 64'h0, 4'd0, 8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE, 64'h0, 4'd0, 64'h0, 4'd0, 8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE, 64'h0, 4'd0, 64'h0, 4'd0, 8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE, 64'h0, 4'd0, 64'h0, 4'd0, 8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE, 64'h0, 4'd0, 64'h0, 4'd0, 8'hFF, 1'b1, 1'b1, BARE_END},
    '{ROW_SETUP, 64'h0, 4'd8, 64'h0, 4'd0, 8'h00, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE, 64'h0, 4'd0, 64'h0, 4'd0, 8'h10, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE, 64'h0, 4'd0, 64'h0, 4'd0, 8'h11, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE, 64'h0, 4'd0, 64'h0, 4'd0, 8'h12, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE, 64'h0, 4'd0, 64'h0, 4'd0, 8'h13, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE, 64'h0, 4'd0, 64'h0, 4'd0, 8'h14, 1'b0, 1'b0, NO_RESULT},
    '{ROW_SETUP, 64'h1615, 4'd2, 64'h0, 4'd0, 8'h00, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE, 64'h0, 4'd0, 64'h0, 4'd0, 8'h15, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE, 64'h0, 4'd0, 64'h0, 4'd0, 8'h16, 1'b1, 1'b0, NO_RESULT}
  };

  stream_replace_first_match_core i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_is_final       (in_is_final),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_byte_present  (out_byte_present),
    .out_end_of_string (out_end_of_string),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Effective pattern length: zero counts as one, above the window saturates
  function automatic int unsigned pat_span();
    if (pat_len == 0) return 1;
    if (pat_len > MAX_PATTERN) return MAX_PATTERN;
    return pat_len;
  endfunction

  function automatic void emit_held_oldest();
    if (held_n == 0) return;
    step_out.push_back('{held[0], 1'b1, 1'b0});
    for (int i = 0; i < MAX_PATTERN - 1; i++) held[i] = held[i + 1];
    held_n--;
  endfunction

  // Results caused by one request, left in step_out
  function automatic void rewrite_byte(byte_t b, logic fin);
    int unsigned span;
    int unsigned rlen;
    bit          hit;
    rewritten_t  tail;
    span = pat_span();
    rlen = (rep_len > MAX_REPLACEMENT) ? MAX_REPLACEMENT : rep_len;
    step_out.delete();
    if (replaced) begin
      step_out.push_back('{b, 1'b1, 1'b0});
    end else begin
      if (held_n > MAX_PATTERN - 1) held_n = MAX_PATTERN - 1;
      held[held_n] = b;
      held_n++;
      // a window longer than the pattern only drains, no search
      if (held_n > span) begin
        emit_held_oldest();
      end else if (held_n == span) begin
        hit = 1'b1;
        for (int i = 0; i < span; i++)
          if (held[i] != pat_bytes[8*i +: 8]) hit = 1'b0;
        if (hit) begin
          for (int i = 0; i < rlen; i++) step_out.push_back('{rep_bytes[8*i +: 8], 1'b1, 1'b0});
          held_n   = 0;
          replaced = 1'b1;
        end else begin
          emit_held_oldest();
        end
      end
    end
    // final byte: flush, bare end marker if nothing went out
    if (fin) begin
      while (held_n > 0) emit_held_oldest();
      if (step_out.size() == 0) step_out.push_back(NO_RESULT);
      tail      = step_out.pop_back();
      tail.last = 1'b1;
      step_out.push_back(tail);
      held_n   = 0;
      replaced = 1'b0;
    end
  endfunction

  // Sender: bursts with random gaps, then hold the request until accepted
  task automatic send_request(byte_t b, logic fin, logic typed, rewritten_t want);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_is_final  <= fin;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    rewrite_byte(b, fin);
    if (typed) rewritten_q.push_back(want);
    else foreach (step_out[k]) rewritten_q.push_back(step_out[k]);
  endtask

  // Hold off until every expected result is in, then let the block settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (rewritten_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic load_pattern(logic [63:0] pb, logic [3:0] pl, logic [63:0] rb, logic [3:0] rl);
    wait_idle();
    write_reg(REG_PATTERN_BYTES, pb);
    write_reg(REG_PATTERN_LENGTH, {60'd0, pl});
    write_reg(REG_REPLACEMENT_BYTES, rb);
    write_reg(REG_REPLACEMENT_LENGTH, {60'd0, rl});
    cfg_we    <= 1'b0;
    pat_bytes = pb;
    pat_len   = pl;
    rep_bytes = rb;
    rep_len   = rl;
  endtask

  // Receiver stall pattern: free, choppy and heavy stretches
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 2));
      rx_left <= $urandom_range(5, 40);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_FREE:   out_stall <= 1'b0;
      RX_CHOPPY: out_stall <= ($urandom_range(0, 3) == 0);
      default:   out_stall <= ($urandom_range(0, 1) == 0);
    endcase
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (out_valid === 1'b1 && out_stall == 1'b0) begin
      if (rewritten_q.size() == 0) begin
        $error("unexpected result: out_byte %h present %b end %b",
               out_byte, out_byte_present, out_end_of_string);
        errors++;
      end else begin
        got_want = rewritten_q.pop_front();
        if (out_byte !== got_want.data) begin
          $error("out_byte: expected %h, got %h", got_want.data, out_byte);
          errors++;
        end
        if (out_byte_present !== got_want.present) begin
          $error("out_byte_present: expected %b, got %b", got_want.present, out_byte_present);
          errors++;
        end
        if (out_end_of_string !== got_want.last) begin
          $error("out_end_of_string: expected %b, got %b", got_want.last, out_end_of_string);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned      random_sent;
    int unsigned      strings_left;
    int unsigned      len;
    int unsigned      at;
    int unsigned      cut;
    int unsigned      span;
    bit               alpha;
    byte_t            text [32];
    logic [63:0]      pb;
    logic [63:0]      rb;
    logic [3:0]       pl;
    logic [3:0]       rl;
    random_sent  = 0;
    strings_left = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed plan
    foreach (plan[r]) begin
      if (plan[r].kind == ROW_SETUP)
        load_pattern(plan[r].pb, plan[r].pl, plan[r].rb, plan[r].rl);
      else
        send_request(plan[r].data, plan[r].fin, plan[r].typed, plan[r].want);
    end

    // random strings, most of them carrying the pattern somewhere
    while (random_sent < RANDOM_ITEMS) begin
      if (strings_left == 0) begin
        alpha = ($urandom_range(0, 2) != 0);
        for (int j = 0; j < 8; j++)
          pb[8*j +: 8] = alpha ? 8'h61 + 8'($urandom_range(0, 2)) : 8'($urandom);
        pl = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 4));
        rb = {$urandom, $urandom};
        rl = 4'($urandom_range(0, 15));
        load_pattern(pb, pl, rb, rl);
        strings_left = $urandom_range(1, 4);
      end
      strings_left--;
      len   = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 9);
      alpha = ($urandom_range(0, 2) != 0);
      for (int i = 0; i < len; i++)
        text[i] = alpha ? 8'h61 + 8'($urandom_range(0, 2)) : 8'($urandom);
      span = pat_span();
      if ($urandom_range(0, 9) < 6 && span <= len) begin
        at = $urandom_range(0, len - span);
        for (int j = 0; j < span; j++) text[at + j] = pat_bytes[8*j +: 8];
      end
      // now and then the pattern length changes in the middle of a string
      cut = ($urandom_range(0, 7) == 0 && len > 2) ? $urandom_range(1, len - 1) : len;
      for (int i = 0; i < len; i++) begin
        if (i == cut) load_pattern(pat_bytes, 4'($urandom_range(0, 15)), rep_bytes, rep_len);
        send_request(text[i], (i == len - 1), 1'b0, NO_RESULT);
        random_sent++;
      end
    end

    wait_idle();
    if (errors == 0) begin
      $display("PASS stream_replace_first_match_core");
    end else begin
      $display("FAIL stream_replace_first_match_core");
    end
    $finish;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("FAIL stream_replace_first_match_core");
    $finish;
  end

endmodule
